FILE: rtl/core/rcs_pkg.sv
// Shared widths, limits and register codes for the raycast column setup block.
`timescale 1ns / 1ps
package rcs_pkg;
	localparam int MAP_BITS    = 8;
	localparam int FRAC_BITS   = 16;
	localparam int COLUMN_BITS = 12;
	localparam int POS_BITS    = MAP_BITS + FRAC_BITS;
	localparam int DIR_BITS    = 18;
	localparam int RAY_BITS    = 19;
	localparam int WIDTH_BITS  = 13;
	localparam int CAM_NUM_BITS = COLUMN_BITS + FRAC_BITS + 1;
	localparam int DEL_NUM_BITS = RAY_BITS + FRAC_BITS;
	localparam int SQ_BITS     = 2 * RAY_BITS;
	localparam int ADDR_BITS   = 5;

	typedef enum logic [2:0] {
		REG_POS_X,
		REG_POS_Y,
		REG_VIEW_DIR_X,
		REG_VIEW_DIR_Y,
		REG_PLANE_X,
		REG_PLANE_Y,
		REG_SCREEN_WIDTH
	} reg_idx_t;
endpackage

FILE: rtl/core/rcs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`timescale 1ns / 1ps
module rcs_div #(
	parameter int NW = 29,
	parameter int DW = 13,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay,
	output logic [NW-1:0] quo,
	output logic [PW-1:0] pay_out
);
	logic [NW-1:0] n_s [1:NW];
	logic [DW-1:0] r_s [1:NW];
	logic [DW-1:0] d_s [1:NW];
	logic [PW-1:0] p_s [1:NW];

	for (genvar k = 1; k <= NW; k++) begin : g_stage
		logic [NW-1:0] n_p;
		logic [DW-1:0] r_p;
		logic [DW-1:0] d_p;
		logic [PW-1:0] p_p;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;
		if (k == 1) begin : g_first
			always_comb begin
				n_p = num;
				r_p = '0;
				d_p = den;
				p_p = pay;
			end
		end else begin : g_next
			always_comb begin
				n_p = n_s[k-1];
				r_p = r_s[k-1];
				d_p = d_s[k-1];
				p_p = p_s[k-1];
			end
		end
		always_comb begin
			trial = {r_p, n_p[NW-1]};
			diff  = trial - {1'b0, d_p};
			ge    = trial >= {1'b0, d_p};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				n_s[k] <= '0;
				r_s[k] <= '0;
				d_s[k] <= '0;
				p_s[k] <= '0;
			end else if (en) begin
				n_s[k] <= {n_p[NW-2:0], ge};
				r_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				d_s[k] <= d_p;
				p_s[k] <= p_p;
			end
		end
	end

	assign quo     = n_s[NW];
	assign pay_out = p_s[NW];
endmodule

FILE: rtl/core/rcs_sqrt.sv
// Pipelined integer square root, one root bit per stage, with side payload.
`timescale 1ns / 1ps
module rcs_sqrt #(
	parameter int RW = 19,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	input  logic [PW-1:0]   pay,
	output logic [RW-1:0]   root,
	output logic [PW-1:0]   pay_out
);
	logic [2*RW-1:0] x_s [1:RW];
	logic [RW+1:0]   r_s [1:RW];
	logic [RW-1:0]   q_s [1:RW];
	logic [PW-1:0]   p_s [1:RW];

	for (genvar k = 1; k <= RW; k++) begin : g_stage
		logic [2*RW-1:0] x_p;
		logic [RW+1:0]   r_p;
		logic [RW-1:0]   q_p;
		logic [PW-1:0]   p_p;
		logic [RW+2:0]   t;
		logic [RW+2:0]   c;
		logic [RW+2:0]   diff;
		logic            ge;
		if (k == 1) begin : g_first
			always_comb begin
				x_p = rad;
				r_p = '0;
				q_p = '0;
				p_p = pay;
			end
		end else begin : g_next
			always_comb begin
				x_p = x_s[k-1];
				r_p = r_s[k-1];
				q_p = q_s[k-1];
				p_p = p_s[k-1];
			end
		end
		always_comb begin
			t    = {r_p[RW:0], x_p[2*RW-1:2*RW-2]};
			c    = {1'b0, q_p, 2'b01};
			diff = t - c;
			ge   = t >= c;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				x_s[k] <= '0;
				r_s[k] <= '0;
				q_s[k] <= '0;
				p_s[k] <= '0;
			end else if (en) begin
				x_s[k] <= {x_p[2*RW-3:0], 2'b00};
				r_s[k] <= ge ? diff[RW+1:0] : t[RW+1:0];
				q_s[k] <= {q_p[RW-2:0], ge};
				p_s[k] <= p_p;
			end
		end
	end

	assign root    = q_s[RW];
	assign pay_out = p_s[RW];
endmodule

FILE: rtl/core/raycast_column_setup.sv
// Top level: config registers and per-column ray setup pipeline.
// Throughput: one column per cycle; a stalled output freezes the whole pipeline.
// The pipeline holds the 29-stage camera divider, 19-stage square root and 35-stage delta dividers.
// Reset clears all valid bits and loads the config registers with their defaults.
`timescale 1ns / 1ps
module raycast_column_setup (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rcs_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rcs_pkg::COLUMN_BITS-1:0]    column,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rcs_pkg::MAP_BITS-1:0]       cell_x,
	output logic [rcs_pkg::MAP_BITS-1:0]       cell_y,
	output logic                               step_x_negative,
	output logic                               step_y_negative,
	output logic signed [rcs_pkg::RAY_BITS-1:0] ray_dir_x,
	output logic signed [rcs_pkg::RAY_BITS-1:0] ray_dir_y,
	output logic [31:0]                        delta_x,
	output logic [31:0]                        delta_y,
	output logic [31:0]                        side_x,
	output logic [31:0]                        side_y
);
	localparam int RB = rcs_pkg::RAY_BITS;
	localparam int FB = rcs_pkg::FRAC_BITS;
	localparam int CNB = rcs_pkg::CAM_NUM_BITS;
	localparam int DNB = rcs_pkg::DEL_NUM_BITS;

	logic [rcs_pkg::POS_BITS-1:0]          pos_x_q, pos_y_q;
	logic signed [rcs_pkg::DIR_BITS-1:0]   view_dir_x_q, view_dir_y_q, plane_x_q, plane_y_q;
	logic [rcs_pkg::WIDTH_BITS-1:0]        screen_width_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			view_dir_x_q   <= 18'sd65535;
			view_dir_y_q   <= '0;
			plane_x_q      <= '0;
			plane_y_q      <= 18'sd43254;
			screen_width_q <= 13'd640;
		end else if (psel && penable && pwrite) begin
			unique case (rcs_pkg::reg_idx_t'(paddr[4:2]))
				rcs_pkg::REG_POS_X:        pos_x_q <= pwdata[rcs_pkg::POS_BITS-1:0];
				rcs_pkg::REG_POS_Y:        pos_y_q <= pwdata[rcs_pkg::POS_BITS-1:0];
				rcs_pkg::REG_VIEW_DIR_X:   view_dir_x_q <= pwdata[rcs_pkg::DIR_BITS-1:0];
				rcs_pkg::REG_VIEW_DIR_Y:   view_dir_y_q <= pwdata[rcs_pkg::DIR_BITS-1:0];
				rcs_pkg::REG_PLANE_X:      plane_x_q <= pwdata[rcs_pkg::DIR_BITS-1:0];
				rcs_pkg::REG_PLANE_Y:      plane_y_q <= pwdata[rcs_pkg::DIR_BITS-1:0];
				rcs_pkg::REG_SCREEN_WIDTH: screen_width_q <= pwdata[rcs_pkg::WIDTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (rcs_pkg::reg_idx_t'(paddr[4:2]))
			rcs_pkg::REG_POS_X:        prdata = 32'(pos_x_q);
			rcs_pkg::REG_POS_Y:        prdata = 32'(pos_y_q);
			rcs_pkg::REG_VIEW_DIR_X:   prdata = 32'(unsigned'(view_dir_x_q));
			rcs_pkg::REG_VIEW_DIR_Y:   prdata = 32'(unsigned'(view_dir_y_q));
			rcs_pkg::REG_PLANE_X:      prdata = 32'(unsigned'(plane_x_q));
			rcs_pkg::REG_PLANE_Y:      prdata = 32'(unsigned'(plane_y_q));
			rcs_pkg::REG_SCREEN_WIDTH: prdata = 32'(screen_width_q);
			default:                   prdata = '0;
		endcase
	end

	// global advance: whole pipeline holds while the output word waits
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// camera divider
	logic [rcs_pkg::WIDTH_BITS-1:0] w_eff;
	logic [CNB-1:0] cam_q;
	logic           cam_v;
	assign w_eff = (screen_width_q == '0) ? rcs_pkg::WIDTH_BITS'(1) : screen_width_q;

	rcs_div #(.NW(CNB), .DW(rcs_pkg::WIDTH_BITS), .PW(1)) u_div_cam (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({column, {(FB + 1){1'b0}}}), .den(w_eff), .pay(in_valid && in_ready),
		.quo(cam_q), .pay_out(cam_v)
	);

	logic              v_s1;
	logic signed [CNB:0] cam_s1;
	logic              v_s2;
	logic signed [CNB+rcs_pkg::DIR_BITS:0] px_s2, py_s2;
	logic              v_s3;
	logic signed [RB-1:0] rx_s3, ry_s3;
	logic              v_s4;
	logic signed [RB-1:0] rx_s4, ry_s4;
	logic [rcs_pkg::SQ_BITS-1:0] sx_s4, sy_s4;
	logic              v_s5;
	logic signed [RB-1:0] rx_s5, ry_s5;
	logic [rcs_pkg::SQ_BITS-1:0] sum_s5;

	logic signed [32:0] ax3, ay3;

	always_comb begin
		ax3 = 33'(view_dir_x_q) + 33'(signed'(px_s2[CNB+rcs_pkg::DIR_BITS:FB]));
		ay3 = 33'(view_dir_y_q) + 33'(signed'(py_s2[CNB+rcs_pkg::DIR_BITS:FB]));
	end

	function automatic logic signed [rcs_pkg::RAY_BITS-1:0] sat_ray(input logic signed [32:0] v);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		hi = 33'sd262143;
		lo = -33'sd262144;
		if (v > hi)
			sat_ray = rcs_pkg::RAY_BITS'(hi);
		else if (v < lo)
			sat_ray = rcs_pkg::RAY_BITS'(lo);
		else
			sat_ray = v[rcs_pkg::RAY_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= cam_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cam_s1 <= signed'({1'b0, cam_q}) - (CNB+1)'(1 << FB);
			px_s2  <= plane_x_q * cam_s1;
			py_s2  <= plane_y_q * cam_s1;
			rx_s3  <= sat_ray(ax3);
			ry_s3  <= sat_ray(ay3);
			sx_s4  <= unsigned'(rcs_pkg::SQ_BITS'(rx_s3 * rx_s3));
			sy_s4  <= unsigned'(rcs_pkg::SQ_BITS'(ry_s3 * ry_s3));
			rx_s4  <= rx_s3;
			ry_s4  <= ry_s3;
			sum_s5 <= sx_s4 + sy_s4;
			rx_s5  <= rx_s4;
			ry_s5  <= ry_s4;
		end
	end

	// magnitude
	logic [RB-1:0]      mag;
	logic [2*RB:0]      sq_pay;
	rcs_sqrt #(.RW(RB), .PW(2 * RB + 1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.rad(sum_s5), .pay({v_s5, rx_s5, ry_s5}),
		.root(mag), .pay_out(sq_pay)
	);

	logic              v_s6;
	logic signed [RB-1:0] rx_s6, ry_s6;
	logic [DNB-1:0]    num_s6;
	logic [RB-1:0]     ax_s6, ay_s6;
	logic signed [RB-1:0] rx5, ry5;
	assign rx5 = sq_pay[2*RB-1:RB];
	assign ry5 = sq_pay[RB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= sq_pay[2*RB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6 <= {mag, {FB{1'b0}}};
			ax_s6  <= rx5[RB-1] ? RB'(-rx5) : rx5;
			ay_s6  <= ry5[RB-1] ? RB'(-ry5) : ry5;
			rx_s6  <= rx5;
			ry_s6  <= ry5;
		end
	end

	// delta dividers; a zero divisor yields an all-ones quotient, which saturates
	logic [DNB-1:0] qx, qy;
	logic [RB:0]    dx_pay;
	logic [RB-1:0]  dy_pay;
	rcs_div #(.NW(DNB), .DW(RB), .PW(RB + 1)) u_div_dx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(num_s6), .den(ax_s6), .pay({v_s6, rx_s6}),
		.quo(qx), .pay_out(dx_pay)
	);
	rcs_div #(.NW(DNB), .DW(RB), .PW(RB)) u_div_dy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(num_s6), .den(ay_s6), .pay(ry_s6),
		.quo(qy), .pay_out(dy_pay)
	);

	logic              v_s7, v_s8, v_s9;
	logic signed [RB-1:0] rx_s7, ry_s7, rx_s8, ry_s8, rx_s9, ry_s9;
	logic [31:0]       dx_s7, dy_s7, dx_s8, dy_s8, dx_s9, dy_s9;
	logic [FB:0]       fx_s7, fy_s7;
	logic              fzx_s8, fzy_s8;
	logic [FB+32:0]    px_s8, py_s8;
	logic [31:0]       sdx_s9, sdy_s9;
	logic [FB:0]       fx7, fy7;

	always_comb begin
		fx7 = dx_pay[RB-1] ? {1'b0, pos_x_q[FB-1:0]} : (FB+1)'((1 << FB) - pos_x_q[FB-1:0]);
		fy7 = dy_pay[RB-1] ? {1'b0, pos_y_q[FB-1:0]} : (FB+1)'((1 << FB) - pos_y_q[FB-1:0]);
	end

	function automatic logic [31:0] side_of(input logic fz, input logic [31:0] d,
			input logic [FB+32:0] p);
		if (fz)
			side_of = '0;
		else if (d == 32'hFFFF_FFFF || p[FB+32])
			side_of = 32'hFFFF_FFFF;
		else
			side_of = p[FB+31:FB];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s7 <= dx_pay[RB];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s7  <= (|qx[DNB-1:32]) ? 32'hFFFF_FFFF : qx[31:0];
			dy_s7  <= (|qy[DNB-1:32]) ? 32'hFFFF_FFFF : qy[31:0];
			fx_s7  <= fx7;
			fy_s7  <= fy7;
			rx_s7  <= dx_pay[RB-1:0];
			ry_s7  <= dy_pay;
			px_s8  <= fx_s7 * dx_s7;
			py_s8  <= fy_s7 * dy_s7;
			fzx_s8 <= fx_s7 == '0;
			fzy_s8 <= fy_s7 == '0;
			dx_s8  <= dx_s7;
			dy_s8  <= dy_s7;
			rx_s8  <= rx_s7;
			ry_s8  <= ry_s7;
			sdx_s9 <= side_of(fzx_s8, dx_s8, px_s8);
			sdy_s9 <= side_of(fzy_s8, dy_s8, py_s8);
			dx_s9  <= dx_s8;
			dy_s9  <= dy_s8;
			rx_s9  <= rx_s8;
			ry_s9  <= ry_s8;
		end
	end

	assign out_valid       = v_s9;
	assign cell_x          = pos_x_q[rcs_pkg::POS_BITS-1:FB];
	assign cell_y          = pos_y_q[rcs_pkg::POS_BITS-1:FB];
	assign step_x_negative = rx_s9[RB-1];
	assign step_y_negative = ry_s9[RB-1];
	assign ray_dir_x       = rx_s9;
	assign ray_dir_y       = ry_s9;
	assign delta_x         = dx_s9;
	assign delta_y         = dy_s9;
	assign side_x          = sdx_s9;
	assign side_y          = sdy_s9;
endmodule

FILE: tb/sv/raycast_column_setup_checker.sv
// Checker for raycast_column_setup: tracks config writes, predicts each result word, compares.
`timescale 1ns / 1ps
module raycast_column_setup_checker
	import rcs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_BITS-1:0]       paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [COLUMN_BITS-1:0]     column,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [MAP_BITS-1:0]        cell_x,
	input  logic [MAP_BITS-1:0]        cell_y,
	input  logic                       step_x_negative,
	input  logic                       step_y_negative,
	input  logic signed [RAY_BITS-1:0] ray_dir_x,
	input  logic signed [RAY_BITS-1:0] ray_dir_y,
	input  logic [31:0]                delta_x,
	input  logic [31:0]                delta_y,
	input  logic [31:0]                side_x,
	input  logic [31:0]                side_y,
	output int                         fails,
	output int                         pending
);
	typedef struct {
		logic [MAP_BITS-1:0]        cx, cy;
		logic                       nx, ny;
		logic signed [RAY_BITS-1:0] rx, ry;
		logic [31:0]                dx, dy, sx, sy;
	} ray_setup_t;

	localparam longint DIST_MAX = 64'hFFFF_FFFF;

	logic [POS_BITS-1:0]          pos_x, pos_y;
	logic signed [DIR_BITS-1:0]   dir_x, dir_y, pl_x, pl_y;
	logic [WIDTH_BITS-1:0]        scr_w;
	ray_setup_t                   ray_q[$];

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint clamp_ray(longint v);
		if (v > 262143)
			return 262143;
		if (v < -262144)
			return -262144;
		return v;
	endfunction

	function automatic longint grid_delta(longint mag, longint comp);
		longint a, q;
		a = comp < 0 ? -comp : comp;
		if (a == 0)
			return DIST_MAX;
		q = (mag << FRAC_BITS) / a;
		return q > DIST_MAX ? DIST_MAX : q;
	endfunction

	function automatic longint first_side(logic [POS_BITS-1:0] pos, logic neg, longint dl);
		longint fr, f, p;
		fr = longint'(pos[FRAC_BITS-1:0]);
		f = neg ? fr : (longint'(1) << FRAC_BITS) - fr;
		if (f == 0)
			return 0;
		if (dl == DIST_MAX)
			return DIST_MAX;
		p = (f * dl) >> FRAC_BITS;
		return p > DIST_MAX ? DIST_MAX : p;
	endfunction

	function automatic ray_setup_t predict_ray(logic [COLUMN_BITS-1:0] col);
		ray_setup_t r;
		longint w, cam, rx, ry, mag, dx, dy;
		w = (scr_w == 0) ? 1 : longint'(scr_w);
		cam = ((longint'(col) * 2) << FRAC_BITS) / w - (longint'(1) << FRAC_BITS);
		rx = clamp_ray(longint'(dir_x) + ((longint'(pl_x) * cam) >>> FRAC_BITS));
		ry = clamp_ray(longint'(dir_y) + ((longint'(pl_y) * cam) >>> FRAC_BITS));
		mag = longint'(int_sqrt(longint'(rx * rx + ry * ry)));
		dx = grid_delta(mag, rx);
		dy = grid_delta(mag, ry);
		r.cx = pos_x[POS_BITS-1:FRAC_BITS];
		r.cy = pos_y[POS_BITS-1:FRAC_BITS];
		r.nx = rx < 0;
		r.ny = ry < 0;
		r.rx = rx[RAY_BITS-1:0];
		r.ry = ry[RAY_BITS-1:0];
		r.dx = dx[31:0];
		r.dy = dy[31:0];
		r.sx = 32'(first_side(pos_x, r.nx, dx));
		r.sy = 32'(first_side(pos_y, r.ny, dy));
		return r;
	endfunction

	task automatic report_mismatch(string fld, longint got, longint want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, fld, got, want);
		fails++;
	endtask

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		ray_setup_t e;
		if (!arst_n) begin
			pos_x <= '0;
			pos_y <= '0;
			dir_x <= 18'sd65535;
			dir_y <= '0;
			pl_x  <= '0;
			pl_y  <= 18'sd43254;
			scr_w <= 13'd640;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr >> 2)
					REG_POS_X:        pos_x <= pwdata[POS_BITS-1:0];
					REG_POS_Y:        pos_y <= pwdata[POS_BITS-1:0];
					REG_VIEW_DIR_X:   dir_x <= pwdata[DIR_BITS-1:0];
					REG_VIEW_DIR_Y:   dir_y <= pwdata[DIR_BITS-1:0];
					REG_PLANE_X:      pl_x  <= pwdata[DIR_BITS-1:0];
					REG_PLANE_Y:      pl_y  <= pwdata[DIR_BITS-1:0];
					REG_SCREEN_WIDTH: scr_w <= pwdata[WIDTH_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				ray_q.push_back(predict_ray(column));
			if (out_valid && out_ready) begin
				if (ray_q.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					e = ray_q.pop_front();
					if (cell_x !== e.cx) report_mismatch("cell_x", cell_x, e.cx);
					if (cell_y !== e.cy) report_mismatch("cell_y", cell_y, e.cy);
					if (step_x_negative !== e.nx)
						report_mismatch("step_x_negative", step_x_negative, e.nx);
					if (step_y_negative !== e.ny)
						report_mismatch("step_y_negative", step_y_negative, e.ny);
					if (ray_dir_x !== e.rx) report_mismatch("ray_dir_x", ray_dir_x, e.rx);
					if (ray_dir_y !== e.ry) report_mismatch("ray_dir_y", ray_dir_y, e.ry);
					if (delta_x !== e.dx) report_mismatch("delta_x", delta_x, e.dx);
					if (delta_y !== e.dy) report_mismatch("delta_y", delta_y, e.dy);
					if (side_x !== e.sx) report_mismatch("side_x", side_x, e.sx);
					if (side_y !== e.sy) report_mismatch("side_y", side_y, e.sy);
				end
			end
			pending <= ray_q.size();
		end
	end
endmodule

FILE: tb/sv/raycast_column_setup_tb.sv
// Testbench top for raycast_column_setup: clock, reset, column and config stimulus, verdict.
`timescale 1ns / 1ps
module raycast_column_setup_tb;
	import rcs_pkg::*;

	localparam int IDLE_LIMIT = 3000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic [COLUMN_BITS-1:0] column = '0;
	logic out_valid, out_ready = 0;
	logic [MAP_BITS-1:0] cell_x, cell_y;
	logic step_x_negative, step_y_negative;
	logic signed [RAY_BITS-1:0] ray_dir_x, ray_dir_y;
	logic [31:0] delta_x, delta_y, side_x, side_y;
	int fails, pending;

	int send_idle = 30, recv_idle = 74;
	logic hold_req = 0, hold_seen = 0;
	int hold_cnt = 0;
	int idle_cycles = 0;
	int cur_w = 640;

	always #5 clk = ~clk;

	raycast_column_setup u_dut (.*);
	raycast_column_setup_checker u_chk (.*);

	// receiver: random ready, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= 400;
			out_ready <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_column(input logic [COLUMN_BITS-1:0] c);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		column <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_BITS'(idx) << 2;
		pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic load_frame(input logic [23:0] px, py, input logic [17:0] dx, dy, lx, ly,
			input logic [12:0] w);
		drain();
		write_reg(REG_POS_X, 32'(px));
		write_reg(REG_POS_Y, 32'(py));
		write_reg(REG_VIEW_DIR_X, 32'(signed'(dx)));
		write_reg(REG_VIEW_DIR_Y, 32'(signed'(dy)));
		write_reg(REG_PLANE_X, 32'(signed'(lx)));
		write_reg(REG_PLANE_Y, 32'(signed'(ly)));
		write_reg(REG_SCREEN_WIDTH, 32'(w));
		cur_w = (w == 0) ? 1 : (w > 4096 ? 4096 : int'(w));
	endtask

	function automatic logic [17:0] rand_dir();
		case ($urandom_range(0, 4))
			0: return 18'h20000;
			1: return 18'h1FFFF;
			2: return 18'h0;
			3: return 18'($urandom_range(0, 511)) - 18'd256;
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic [12:0] rand_width();
		case ($urandom_range(0, 9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd8191;
			3: return 13'd4096;
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	initial begin
		logic [COLUMN_BITS-1:0] c;
		int n;
		int cols[$];
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// defaults straight out of reset
		cols = {0, 1, 320, 639, 640, 4095};
		foreach (cols[i]) send_column(COLUMN_BITS'(cols[i]));
		// extreme corners
		load_frame(24'hFFFFFF, 24'h0, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000, 13'd1);
		cols = {0, 4095, 1, 2048};
		foreach (cols[i]) send_column(COLUMN_BITS'(cols[i]));
		// zero x direction, whole-cell x position, half-cell y position
		load_frame(24'h050000, 24'hAB8000, 18'h0, 18'h10000, 18'h0, 18'h0, 13'd4096);
		cols = {0, 4095, 2048};
		foreach (cols[i]) send_column(COLUMN_BITS'(cols[i]));
		load_frame(24'h000000, 24'h010000, 18'h10000, 18'h0, 18'h0, 18'h0, 13'd0);
		cols = {0, 4095, 1};
		foreach (cols[i]) send_column(COLUMN_BITS'(cols[i]));
		load_frame(24'h7FFFFF, 24'hFF0000, 18'h3FFFF, 18'h1, 18'h8000, 18'h3C000, 13'd8191);
		cols = {0, 4095, 4094};
		foreach (cols[i]) send_column(COLUMN_BITS'(cols[i]));

		n = 0;
		for (int ph = 0; ph < 5; ph++) begin
			load_frame(24'($urandom), 24'($urandom), rand_dir(), rand_dir(), rand_dir(),
				rand_dir(), rand_width());
			if (ph == 4)
				hold_req <= ~hold_req;
			for (int k = 0; k < 150; k++) begin
				if (n == 250) begin
					send_idle = 74;
					recv_idle = 30;
				end else if (n == 500) begin
					send_idle = 0;
					recv_idle = 0;
				end
				if ($urandom_range(0, 3) != 0)
					c = COLUMN_BITS'($urandom_range(0, cur_w - 1));
				else
					c = COLUMN_BITS'($urandom);
				send_column(c);
				n++;
			end
		end

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
